// ----- rtl/fcva_pkg.sv -----
// ----------------------------------------------------------------------------
// fcva_pkg: shared types and helpers of the four-component vector ALU
// Action codes, sideband and result structs, and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package fcva_pkg;

	localparam int DATA_W        = 32;
	localparam int NUM_LANES     = 4;
	localparam int PROD_W        = 2 * DATA_W;
	localparam int SAT_W         = 68;
	localparam int EPS_W         = 16;
	localparam int RAD_W         = 2 * DATA_W;
	localparam int SQRT_STAGES   = DATA_W;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [EPS_W-1:0]  EPS_RESET = 16'd1;
	localparam logic [DATA_W-1:0] S32_MAX   = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] S32_MIN   = 32'h8000_0000;

	typedef enum logic [3:0] {
		ACT_ADD       = 4'd0,
		ACT_SUB       = 4'd1,
		ACT_NEG       = 4'd2,
		ACT_SCALE     = 4'd3,
		ACT_DIV       = 4'd4,
		ACT_DOT       = 4'd5,
		ACT_CROSS     = 4'd6,
		ACT_NORM      = 4'd7,
		ACT_NORMALIZE = 4'd8,
		ACT_EQUAL     = 4'd9
	} action_t;

	typedef logic [NUM_LANES-1:0][DATA_W-1:0] vec_t;

	// Sideband that travels alongside the square root and divide pipes
	typedef struct packed {
		action_t               action;
		vec_t                  res;
		logic [NUM_LANES-1:0]  res_clip;
		logic [DATA_W-1:0]     dot;
		logic                  dot_clip;
		logic                  eq;
		vec_t                  a_mag;
		logic [NUM_LANES-1:0]  a_neg;
		logic [DATA_W-1:0]     f_mag;
		logic                  f_neg;
		logic                  f_zero;
		logic [DATA_W-1:0]     root;
	} side_t;

	typedef struct packed {
		vec_t              r;
		logic [DATA_W-1:0] scalar;
		logic              is_equal;
		logic              zero_div;
		logic              sat;
	} result_t;

	// Clip a wide signed value to 32 bits; the top bit of the result flags a clip
	function automatic logic [DATA_W:0] sat32(input logic signed [SAT_W-1:0] v);
		logic ovf;
		ovf = !((&v[SAT_W-1:DATA_W-1]) || !(|v[SAT_W-1:DATA_W-1]));
		if (ovf) begin
			return {1'b1, v[SAT_W-1] ? S32_MIN : S32_MAX};
		end
		return {1'b0, v[DATA_W-1:0]};
	endfunction

endpackage

// ----- rtl/four_component_vector_alu.sv -----
// ----------------------------------------------------------------------------
// four_component_vector_alu: Q16.16 vector ALU, one op per cycle if unstalled
// Stages: three front stages, 32 square root stages, one divide stage per
//   quotient bit, one output register.
// Throughput: one item per cycle while in_stall is low; every item runs the
//   full fixed-length pipe.
// Reset: arst_n clears all valid bits and the output skid, eps_q = EPS_RESET (1).
// ----------------------------------------------------------------------------
module four_component_vector_alu #(
	parameter int FRAC_BITS = fcva_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_wr_en,
	input  logic [fcva_pkg::EPS_W-1:0]        cfg_wr_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [3:0]                        action,
	input  logic signed [fcva_pkg::DATA_W-1:0] a_x,
	input  logic signed [fcva_pkg::DATA_W-1:0] a_y,
	input  logic signed [fcva_pkg::DATA_W-1:0] a_z,
	input  logic signed [fcva_pkg::DATA_W-1:0] a_w,
	input  logic signed [fcva_pkg::DATA_W-1:0] b_x,
	input  logic signed [fcva_pkg::DATA_W-1:0] b_y,
	input  logic signed [fcva_pkg::DATA_W-1:0] b_z,
	input  logic signed [fcva_pkg::DATA_W-1:0] b_w,
	input  logic signed [fcva_pkg::DATA_W-1:0] factor,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [fcva_pkg::DATA_W-1:0] r_x,
	output logic signed [fcva_pkg::DATA_W-1:0] r_y,
	output logic signed [fcva_pkg::DATA_W-1:0] r_z,
	output logic signed [fcva_pkg::DATA_W-1:0] r_w,
	output logic signed [fcva_pkg::DATA_W-1:0] r_scalar,
	output logic                              is_equal,
	output logic                              zero_divisor,
	output logic                              saturated
);
	import fcva_pkg::*;

	localparam int NS = SQRT_STAGES;
	localparam int QW = DATA_W + FRAC_BITS;

	// ------------------------------------------------------------------
	// Flow control: the whole pipe advances unless the skid slot is full.
	// The skid catches the one result that arrives while the output
	// register is held, so input keeps flowing for that cycle.
	// ------------------------------------------------------------------
	logic    adv;
	logic    out_vld_q, skid_full_q;
	result_t out_data_q, skid_data_q, merged;

	assign adv      = !skid_full_q;
	assign in_stall = skid_full_q;

	// tolerance register
	logic [EPS_W-1:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_wr_en) begin
			eps_q <= cfg_wr_data;
		end
	end

	// ------------------------------------------------------------------
	// Front stages
	// ------------------------------------------------------------------
	action_t act_in, act_s1, act_s2;
	vec_t    a_vec, b_vec;

	assign act_in = action_t'(action);
	assign a_vec  = {a_w, a_z, a_y, a_x};
	assign b_vec  = {b_w, b_z, b_y, b_x};

	logic signed [PROD_W-1:0] p0_s1    [NUM_LANES];
	logic [DATA_W-1:0]        res_s2   [NUM_LANES];
	logic [DATA_W-1:0]        amag_s2  [NUM_LANES];
	logic [NUM_LANES-1:0]     clip_s2, eq_s2, aneg_s2;

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		fcva_lane #(
			.FRAC_BITS (FRAC_BITS),
			.LANE      (i)
		) u_lane (
			.clk         (clk),
			.adv         (adv),
			.act         (act_in),
			.a           (a_vec),
			.b           (b_vec),
			.f           (factor),
			.act_s1      (act_s1),
			.eps         (eps_q),
			.p0_s1       (p0_s1[i]),
			.res_s2      (res_s2[i]),
			.res_clip_s2 (clip_s2[i]),
			.eq_s2       (eq_s2[i]),
			.amag_s2     (amag_s2[i]),
			.aneg_s2     (aneg_s2[i])
		);
	end

	// scalar operand for divide, carried to the side struct
	logic [DATA_W-1:0] fmag_s1, fmag_s2;
	logic              fneg_s1, fneg_s2, fzero_s1, fzero_s2;
	// dot / sum of squares partial sums
	logic signed [PROD_W:0] sum01_s2, sum23_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1   <= act_in;
			fneg_s1  <= factor[DATA_W-1];
			fmag_s1  <= factor[DATA_W-1] ? DATA_W'(-(DATA_W+1)'(factor)) : factor;
			fzero_s1 <= (factor == '0);
			act_s2   <= act_s1;
			fneg_s2  <= fneg_s1;
			fmag_s2  <= fmag_s1;
			fzero_s2 <= fzero_s1;
			sum01_s2 <= (PROD_W+1)'(p0_s1[0]) + (PROD_W+1)'(p0_s1[1]);
			sum23_s2 <= (PROD_W+1)'(p0_s1[2]) + (PROD_W+1)'(p0_s1[3]);
		end
	end

	// stage 3: final sum, dot clip, radicand for the norm
	logic signed [PROD_W+1:0] total, dot_sh;
	logic [DATA_W:0]          dot_sat;
	logic [RAD_W-1:0]         rad_s3;
	side_t                    side_s3;

	always_comb begin
		total   = (PROD_W+2)'(sum01_s2) + (PROD_W+2)'(sum23_s2);
		dot_sh  = total >>> FRAC_BITS;
		dot_sat = sat32(SAT_W'(dot_sh));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// sum of four squares tops out at 2^64; pin that one case to all ones
			rad_s3           <= total[PROD_W] ? '1 : total[RAD_W-1:0];
			side_s3.action   <= act_s2;
			side_s3.dot      <= dot_sat[DATA_W-1:0];
			side_s3.dot_clip <= dot_sat[DATA_W];
			side_s3.eq       <= &eq_s2;
			side_s3.f_mag    <= fmag_s2;
			side_s3.f_neg    <= fneg_s2;
			side_s3.f_zero   <= fzero_s2;
			side_s3.res_clip <= clip_s2;
			side_s3.a_neg    <= aneg_s2;
			side_s3.root     <= '0;
			for (int i = 0; i < NUM_LANES; i++) begin
				side_s3.res[i]   <= res_s2[i];
				side_s3.a_mag[i] <= amag_s2[i];
			end
		end
	end

	// ------------------------------------------------------------------
	// Square root, then one divider per lane. The divisor is the norm
	// for normalize and |factor| otherwise.
	// ------------------------------------------------------------------
	logic [DATA_W-1:0] root;

	fcva_sqrt u_sqrt (
		.clk  (clk),
		.adv  (adv),
		.rad  (rad_s3),
		.root (root)
	);

	side_t sdq1 [NS];
	side_t sdq2 [QW];
	side_t side_div;

	logic [NUM_LANES-1:0][QW-1:0] num, quot;
	logic [DATA_W-1:0]            den;

	always_comb begin
		side_div      = sdq1[NS-1];
		side_div.root = root;
		den           = (side_div.action == ACT_NORMALIZE) ? root : side_div.f_mag;
		for (int i = 0; i < NUM_LANES; i++) begin
			num[i] = {side_div.a_mag[i], {FRAC_BITS{1'b0}}};
		end
	end

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_div
		fcva_div #(
			.FRAC_BITS (FRAC_BITS)
		) u_div (
			.clk  (clk),
			.adv  (adv),
			.num  (num[i]),
			.den  (den),
			.quot (quot[i])
		);
	end

	// sideband delay lines, aligned with the sqrt and divide pipes
	always_ff @(posedge clk) begin
		if (adv) begin
			sdq1[0] <= side_s3;
			for (int k = 1; k < NS; k++) begin
				sdq1[k] <= sdq1[k-1];
			end
			sdq2[0] <= side_div;
			for (int k = 1; k < QW; k++) begin
				sdq2[k] <= sdq2[k-1];
			end
		end
	end

	// valid bits for every stage
	logic          v_s1, v_s2, v_s3;
	logic [NS-1:0] vq1;
	logic [QW-1:0] vq2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			vq1  <= '0;
			vq2  <= '0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			vq1  <= {vq1[NS-2:0], v_s3};
			vq2  <= {vq2[QW-2:0], vq1[NS-1]};
		end
	end

	fcva_merge #(
		.FRAC_BITS (FRAC_BITS)
	) u_merge (
		.side (sdq2[QW-1]),
		.quot (quot),
		.res  (merged)
	);

	// ------------------------------------------------------------------
	// Output register plus one skid slot
	// ------------------------------------------------------------------
	logic new_item;

	assign new_item = vq2[QW-1] && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (!out_vld_q || !out_stall) begin
			// output slot frees up: drain the skid first
			if (skid_full_q) begin
				out_vld_q   <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				out_vld_q <= new_item;
			end
		end else if (new_item) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || !out_stall) begin
			out_data_q <= skid_full_q ? skid_data_q : merged;
		end else if (new_item) begin
			skid_data_q <= merged;
		end
	end

	assign out_valid    = out_vld_q;
	assign r_x          = out_data_q.r[0];
	assign r_y          = out_data_q.r[1];
	assign r_z          = out_data_q.r[2];
	assign r_w          = out_data_q.r[3];
	assign r_scalar     = out_data_q.scalar;
	assign is_equal     = out_data_q.is_equal;
	assign zero_divisor = out_data_q.zero_div;
	assign saturated    = out_data_q.sat;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_vld_q)
		else $error("skid holds a result while the output register is empty");

	a_skid_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(out_vld_q && out_stall))
		else $error("skid filled without a held output transfer");

	a_zdiv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_data_q.zero_div |->
			out_data_q.r == '0 && out_data_q.scalar == '0 && !out_data_q.sat)
		else $error("zero divisor result is not the zero vector");

	a_equal_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_data_q.is_equal |->
			!out_data_q.zero_div && !out_data_q.sat && out_data_q.r == '0)
		else $error("equal result carries other fields");

endmodule

// ----- rtl/fcva_lane.sv -----
// ----------------------------------------------------------------------------
// fcva_lane: per-component front end
// Two multipliers, add/subtract/negate, floor shift and saturation for one
// component, plus the tolerance test and the magnitude for the divider.
// ----------------------------------------------------------------------------
module fcva_lane #(
	parameter int FRAC_BITS = fcva_pkg::FRAC_BITS_DEF,
	parameter int LANE      = 0
) (
	input  logic                                clk,
	input  logic                                adv,
	input  fcva_pkg::action_t                   act,
	input  fcva_pkg::vec_t                      a,
	input  fcva_pkg::vec_t                      b,
	input  logic [fcva_pkg::DATA_W-1:0]         f,
	input  fcva_pkg::action_t                   act_s1,
	input  logic [fcva_pkg::EPS_W-1:0]          eps,
	output logic signed [fcva_pkg::PROD_W-1:0]  p0_s1,
	output logic [fcva_pkg::DATA_W-1:0]         res_s2,
	output logic                                res_clip_s2,
	output logic                                eq_s2,
	output logic [fcva_pkg::DATA_W-1:0]         amag_s2,
	output logic                                aneg_s2
);
	import fcva_pkg::*;

	localparam int   J         = (LANE + 1) % 3;
	localparam int   K         = (LANE + 2) % 3;
	localparam logic HAS_CROSS = (LANE < 3);

	logic signed [DATA_W-1:0] m0a, m0b, m1a, m1b;
	logic signed [PROD_W-1:0] prod0, prod1, p1_s1;
	logic signed [DATA_W:0]   sa, sb, simple, simple_s1;
	logic [DATA_W-1:0]        amag_s1;
	logic                     aneg_s1;

	// operand select for the two multipliers
	always_comb begin
		m0a = a[LANE];
		m0b = '0;
		m1a = '0;
		m1b = '0;
		unique case (act)
			ACT_SCALE:               m0b = f;
			ACT_DOT:                 m0b = b[LANE];
			ACT_NORM, ACT_NORMALIZE: m0b = a[LANE];
			ACT_CROSS: begin
				if (HAS_CROSS) begin
					m0a = a[J];
					m0b = b[K];
					m1a = a[K];
					m1b = b[J];
				end else begin
					m0a = '0;
				end
			end
			default:                 m0a = '0;
		endcase
	end

	assign prod0 = m0a * m0b;
	assign prod1 = m1a * m1b;

	always_comb begin
		sa = {a[LANE][DATA_W-1], a[LANE]};
		sb = {b[LANE][DATA_W-1], b[LANE]};
		unique case (act)
			ACT_ADD: simple = sa + sb;
			ACT_NEG: simple = -sa;
			default: simple = sa - sb;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s1     <= prod0;
			p1_s1     <= prod1;
			simple_s1 <= simple;
			aneg_s1   <= a[LANE][DATA_W-1];
			amag_s1   <= sa[DATA_W] ? DATA_W'(-sa) : a[LANE];
		end
	end

	// stage 2: combine, floor shift, clip
	logic signed [PROD_W:0]   cdiff, cdiff_sh;
	logic signed [PROD_W-1:0] p0_sh;
	logic signed [SAT_W-1:0]  val;
	logic [DATA_W:0]          sat_v, dmag;

	always_comb begin
		cdiff    = (PROD_W+1)'(p0_s1) - (PROD_W+1)'(p1_s1);
		cdiff_sh = cdiff >>> FRAC_BITS;
		p0_sh    = p0_s1 >>> FRAC_BITS;
		unique case (act_s1)
			ACT_ADD, ACT_SUB, ACT_NEG: val = SAT_W'(simple_s1);
			ACT_SCALE:                 val = SAT_W'(p0_sh);
			ACT_CROSS:                 val = SAT_W'(cdiff_sh);
			default:                   val = '0;
		endcase
		sat_v = sat32(val);
		dmag  = simple_s1[DATA_W] ? (DATA_W+1)'(-simple_s1) : (DATA_W+1)'(simple_s1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2      <= sat_v[DATA_W-1:0];
			res_clip_s2 <= sat_v[DATA_W];
			eq_s2       <= dmag < (DATA_W+1)'(eps);
			amag_s2     <= amag_s1;
			aneg_s2     <= aneg_s1;
		end
	end

endmodule

// ----- rtl/fcva_sqrt.sv -----
// ----------------------------------------------------------------------------
// fcva_sqrt: pipelined integer square root
// Restoring digit-by-digit root of a 64-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
module fcva_sqrt (
	input  logic                         clk,
	input  logic                         adv,
	input  logic [fcva_pkg::RAD_W-1:0]   rad,
	output logic [fcva_pkg::DATA_W-1:0]  root
);
	import fcva_pkg::*;

	localparam int NS   = SQRT_STAGES;
	localparam int RW   = DATA_W + 1;
	localparam int STW  = RW + DATA_W + RAD_W;

	logic [RW-1:0]     rem_q  [NS];
	logic [DATA_W-1:0] root_q [NS];
	logic [RAD_W-1:0]  rad_q  [NS];
	logic [STW-1:0]    nxt    [NS];

	function automatic logic [STW-1:0] sq_step(input logic [RW-1:0] r_in,
		input logic [DATA_W-1:0] q_in, input logic [RAD_W-1:0] s_in);
		logic [RW+1:0] t, trial;
		t     = {r_in, s_in[RAD_W-1:RAD_W-2]};
		trial = {1'b0, q_in, 2'b01};
		if (t >= trial) begin
			return {RW'(t - trial), q_in[DATA_W-2:0], 1'b1, s_in[RAD_W-3:0], 2'b00};
		end
		return {t[RW-1:0], q_in[DATA_W-2:0], 1'b0, s_in[RAD_W-3:0], 2'b00};
	endfunction

	always_comb begin
		nxt[0] = sq_step('0, '0, rad);
		for (int k = 1; k < NS; k++) begin
			nxt[k] = sq_step(rem_q[k-1], root_q[k-1], rad_q[k-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NS; k++) begin
				{rem_q[k], root_q[k], rad_q[k]} <= nxt[k];
			end
		end
	end

	assign root = root_q[NS-1];

endmodule

// ----- rtl/fcva_div.sv -----
// ----------------------------------------------------------------------------
// fcva_div: pipelined unsigned divider for one lane
// Restoring division, one quotient bit per stage, divisor carried along.
// ----------------------------------------------------------------------------
module fcva_div #(
	parameter int FRAC_BITS = fcva_pkg::FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    adv,
	input  logic [fcva_pkg::DATA_W+FRAC_BITS-1:0]   num,
	input  logic [fcva_pkg::DATA_W-1:0]             den,
	output logic [fcva_pkg::DATA_W+FRAC_BITS-1:0]   quot
);
	import fcva_pkg::*;

	localparam int QW  = DATA_W + FRAC_BITS;
	localparam int STW = DATA_W + QW + DATA_W;

	logic [DATA_W-1:0] rem_q [QW];
	logic [QW-1:0]     nq_q  [QW];
	logic [DATA_W-1:0] den_q [QW];
	logic [STW-1:0]    nxt   [QW];

	// numerator bits shift out the top while quotient bits shift in below
	function automatic logic [STW-1:0] div_step(input logic [DATA_W-1:0] r_in,
		input logic [QW-1:0] q_in, input logic [DATA_W-1:0] d_in);
		logic [DATA_W:0] t;
		t = {r_in, q_in[QW-1]};
		if (t >= {1'b0, d_in}) begin
			return {DATA_W'(t - {1'b0, d_in}), q_in[QW-2:0], 1'b1, d_in};
		end
		return {t[DATA_W-1:0], q_in[QW-2:0], 1'b0, d_in};
	endfunction

	always_comb begin
		nxt[0] = div_step('0, num, den);
		for (int k = 1; k < QW; k++) begin
			nxt[k] = div_step(rem_q[k-1], nq_q[k-1], den_q[k-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < QW; k++) begin
				{rem_q[k], nq_q[k], den_q[k]} <= nxt[k];
			end
		end
	end

	assign quot = nq_q[QW-1];

endmodule

// ----- rtl/fcva_merge.sv -----
// ----------------------------------------------------------------------------
// fcva_merge: result assembly
// Signs and clips the lane quotients and picks the fields for the action.
// ----------------------------------------------------------------------------
module fcva_merge #(
	parameter int FRAC_BITS = fcva_pkg::FRAC_BITS_DEF
) (
	input  fcva_pkg::side_t                                              side,
	input  logic [fcva_pkg::NUM_LANES-1:0][fcva_pkg::DATA_W+FRAC_BITS-1:0] quot,
	output fcva_pkg::result_t                                            res
);
	import fcva_pkg::*;

	localparam int QW = DATA_W + FRAC_BITS;

	vec_t                    qv;
	logic [NUM_LANES-1:0]    qclip;
	logic                    zdiv, neg;
	logic signed [SAT_W-1:0] qs;
	logic [DATA_W:0]         qsat;

	always_comb begin
		zdiv = ((side.action == ACT_DIV) && side.f_zero) ||
		       ((side.action == ACT_NORMALIZE) && (side.root == '0));
		for (int i = 0; i < NUM_LANES; i++) begin
			neg  = side.a_neg[i] ^ ((side.action == ACT_DIV) && side.f_neg);
			qs   = SAT_W'(quot[i]);
			if (neg) begin
				qs = -qs;
			end
			qsat     = sat32(qs);
			qv[i]    = qsat[DATA_W-1:0];
			qclip[i] = qsat[DATA_W];
		end

		res = '0;
		unique case (side.action)
			ACT_ADD, ACT_SUB, ACT_NEG, ACT_SCALE, ACT_CROSS: begin
				res.r   = side.res;
				res.sat = |side.res_clip;
			end
			ACT_DIV, ACT_NORMALIZE: begin
				res.zero_div = zdiv;
				if (!zdiv) begin
					res.r   = qv;
					res.sat = |qclip;
				end
			end
			ACT_DOT: begin
				res.scalar = side.dot;
				res.sat    = side.dot_clip;
			end
			ACT_NORM: begin
				res.scalar = side.root[DATA_W-1] ? S32_MAX : side.root;
				res.sat    = side.root[DATA_W-1];
			end
			ACT_EQUAL: res.is_equal = side.eq;
			default: ;
		endcase
	end

endmodule

// ----- dv/tb_four_component_vector_alu.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_four_component_vector_alu: self-checking bench of the Q16.16 vector ALU
// A directed table covers the extremes, every action and the zero-divisor,
// saturation and tolerance cases. Random traffic follows under several epsilon
// settings. Results are checked in order against a local model or typed rows.
// ----------------------------------------------------------------------------
module tb_four_component_vector_alu;
	import fcva_pkg::*;

	localparam int FRAC     = 16;
	localparam int PERIOD_H = 2;
	localparam int DRAIN    = 120;      // beyond the depth of the pipe
	localparam int LIMIT    = 600000;   // cycles before the run is declared hung
	localparam int PHASES   = 6;
	localparam int PER_PHASE = 242;

	typedef logic signed [71:0] wide_t;

	typedef struct {
		logic [3:0]         act;
		logic [3:0][31:0]   a;
		logic [3:0][31:0]   b;
		logic [31:0]        f;
	} vec_op_t;

	typedef struct {
		logic [3:0][31:0] r;
		logic [31:0]      scalar;
		logic             eq;
		logic             zdiv;
		logic             sat;
	} vec_res_t;

	typedef struct {
		vec_op_t  op;
		bit       typed;   // use the hand-written result below
		vec_res_t want;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [EPS_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [3:0] action = '0;
	logic signed [31:0] a_x = '0, a_y = '0, a_z = '0, a_w = '0;
	logic signed [31:0] b_x = '0, b_y = '0, b_z = '0, b_w = '0;
	logic signed [31:0] factor = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] r_x, r_y, r_z, r_w, r_scalar;
	logic is_equal, zero_divisor, saturated;

	logic [EPS_W-1:0] tol_now = EPS_RESET;
	vec_res_t         pending_results[$];
	int               mismatches = 0;
	int               cycles = 0;
	bit               quiet = 1'b0;    // no idling on either side

	four_component_vector_alu u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
		.b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w), .factor(factor),
		.out_valid(out_valid), .out_stall(out_stall),
		.r_x(r_x), .r_y(r_y), .r_z(r_z), .r_w(r_w), .r_scalar(r_scalar),
		.is_equal(is_equal), .zero_divisor(zero_divisor), .saturated(saturated)
	);

	always begin
		#PERIOD_H clk = 1'b1;
		#PERIOD_H clk = 1'b0;
	end

	// Clip to 32-bit signed and note the clip
	function automatic logic [31:0] clip32(input wide_t v, inout bit hit);
		if (v > 72'sd2147483647) begin
			hit = 1'b1;
			return 32'h7FFF_FFFF;
		end
		if (v < -72'sd2147483648) begin
			hit = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	// Floor of the square root of a value below 2^64
	function automatic wide_t root_floor(input wide_t s);
		wide_t r;
		wide_t t;
		r = 0;
		for (int k = 31; k >= 0; k--) begin
			t = r | (wide_t'(1) <<< k);
			if (t * t <= s)
				r = t;
		end
		return r;
	endfunction

	function automatic vec_res_t vec_alu_result(input vec_op_t op, input logic [EPS_W-1:0] tol);
		wide_t av[4], bv[4], rv[4], fv, sc, sum, n, d;
		vec_res_t res;
		bit hit;
		hit = 1'b0;
		sc = 0;
		res.eq = 1'b0;
		res.zdiv = 1'b0;
		for (int i = 0; i < 4; i++) begin
			av[i] = $signed(op.a[i]);
			bv[i] = $signed(op.b[i]);
			rv[i] = 0;
		end
		fv = $signed(op.f);
		case (op.act)
			ACT_ADD: for (int i = 0; i < 4; i++) rv[i] = av[i] + bv[i];
			ACT_SUB: for (int i = 0; i < 4; i++) rv[i] = av[i] - bv[i];
			ACT_NEG: for (int i = 0; i < 4; i++) rv[i] = -av[i];
			ACT_SCALE: for (int i = 0; i < 4; i++) rv[i] = (av[i] * fv) >>> FRAC;
			ACT_DIV: begin
				if (fv == 0)
					res.zdiv = 1'b1;
				else
					for (int i = 0; i < 4; i++) rv[i] = (av[i] <<< FRAC) / fv;
			end
			ACT_DOT: begin
				sum = 0;
				for (int i = 0; i < 4; i++) sum += av[i] * bv[i];
				sc = sum >>> FRAC;
			end
			ACT_CROSS: begin
				rv[0] = (av[1] * bv[2] - av[2] * bv[1]) >>> FRAC;
				rv[1] = (av[2] * bv[0] - av[0] * bv[2]) >>> FRAC;
				rv[2] = (av[0] * bv[1] - av[1] * bv[0]) >>> FRAC;
			end
			ACT_NORM, ACT_NORMALIZE: begin
				sum = 0;
				for (int i = 0; i < 4; i++) sum += av[i] * av[i];
				// hold the sum of squares below 2^64
				if (sum > 72'sh0_FFFF_FFFF_FFFF_FFFF)
					sum = 72'sh0_FFFF_FFFF_FFFF_FFFF;
				n = root_floor(sum);
				if (op.act == ACT_NORM)
					sc = n;
				else if (n == 0)
					res.zdiv = 1'b1;
				else
					for (int i = 0; i < 4; i++) rv[i] = (av[i] <<< FRAC) / n;
			end
			ACT_EQUAL: begin
				res.eq = 1'b1;
				for (int i = 0; i < 4; i++) begin
					d = av[i] - bv[i];
					if (d < 0)
						d = -d;
					if (!(d < wide_t'({56'b0, tol})))
						res.eq = 1'b0;
				end
			end
			default: ;
		endcase
		for (int i = 0; i < 4; i++) res.r[i] = clip32(rv[i], hit);
		res.scalar = clip32(sc, hit);
		res.sat = hit;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		vec_res_t want;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing expected", 32'(out_valid), 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (r_x !== want.r[0]) report_mismatch("r_x", r_x, want.r[0]);
				if (r_y !== want.r[1]) report_mismatch("r_y", r_y, want.r[1]);
				if (r_z !== want.r[2]) report_mismatch("r_z", r_z, want.r[2]);
				if (r_w !== want.r[3]) report_mismatch("r_w", r_w, want.r[3]);
				if (r_scalar !== want.scalar) report_mismatch("r_scalar", r_scalar, want.scalar);
				if (is_equal !== want.eq)
					report_mismatch("is_equal", 32'(is_equal), 32'(want.eq));
				if (zero_divisor !== want.zdiv)
					report_mismatch("zero_divisor", 32'(zero_divisor), 32'(want.zdiv));
				if (saturated !== want.sat)
					report_mismatch("saturated", 32'(saturated), 32'(want.sat));
			end
		end
	end

	// Receiver stalls in random bursts, with free-running stretches between
	int stall_left = 0;
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= ($urandom_range(0, 2) == 0);
			stall_left <= $urandom_range(0, 14);
		end
	end

	// Declare the run hung past the cycle budget
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL four_component_vector_alu");
			$finish;
		end
	end

	// Present one operation and hold it until the transfer, then queue its result
	task automatic send_op(input vec_op_t op, input bit typed, input vec_res_t want);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= op.act;
		{a_w, a_z, a_y, a_x} <= op.a;
		{b_w, b_z, b_y, b_x} <= op.b;
		factor <= op.f;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(typed ? want : vec_alu_result(op, tol_now));
	endtask

	// Drain the pipe, then write the tolerance
	task automatic set_tolerance(input logic [EPS_W-1:0] tol);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= tol;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tol_now = tol;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 :
				($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF);
			2: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
			3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
			default: return 32'($signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000);
		endcase
	endfunction

	function automatic vec_op_t random_op();
		vec_op_t op;
		int spread;
		op.act = ($urandom_range(0, 30) == 0) ? 4'($urandom_range(10, 15)) :
			4'($urandom_range(ACT_ADD, ACT_EQUAL));
		for (int i = 0; i < 4; i++) begin
			op.a[i] = pick_value();
			op.b[i] = pick_value();
		end
		op.f = ($urandom_range(0, 15) == 0) ? 32'h0 : pick_value();
		if (op.act == ACT_NORMALIZE && $urandom_range(0, 15) == 0)
			op.a = '0;
		// keep b close to a so both outcomes of the tolerance test show up
		if (op.act == ACT_EQUAL && $urandom_range(0, 3) != 0) begin
			spread = 2 * int'(tol_now) + 2;
			for (int i = 0; i < 4; i++)
				op.b[i] = op.a[i] + 32'($urandom_range(0, spread) - spread / 2);
		end
		return op;
	endfunction

	function automatic vec_op_t make_op(input action_t act, input logic [31:0] av,
			input logic [31:0] bv, input logic [31:0] fv);
		vec_op_t op;
		op.act = act;
		op.a = {4{av}};
		op.b = {4{bv}};
		op.f = fv;
		return op;
	endfunction

	function automatic vec_res_t make_res(input logic [31:0] rv, input logic [31:0] sv,
			input bit eq, input bit zd, input bit st);
		vec_res_t res;
		res.r = {4{rv}};
		res.scalar = sv;
		res.eq = eq;
		res.zdiv = zd;
		res.sat = st;
		return res;
	endfunction

	table_row_t directed[$];

	initial begin
		vec_op_t op;
		vec_res_t none;
		none = make_res('0, '0, 0, 0, 0);

		// Extremes and special cases with known results; tolerance is at reset
		directed.push_back('{make_op(ACT_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0), 1,
			make_res(32'h7FFF_FFFF, 0, 0, 0, 1)});
		directed.push_back('{make_op(ACT_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 0), 1,
			make_res(32'h8000_0000, 0, 0, 0, 1)});
		directed.push_back('{make_op(ACT_NEG, 32'h8000_0000, 0, 0), 1,
			make_res(32'h7FFF_FFFF, 0, 0, 0, 1)});
		directed.push_back('{make_op(ACT_DIV, 32'h0003_0000, 0, 0), 1, make_res(0, 0, 0, 1, 0)});
		directed.push_back('{make_op(ACT_NORMALIZE, 0, 32'h1234, 32'h5678), 1,
			make_res(0, 0, 0, 1, 0)});
		directed.push_back('{make_op(ACT_NORM, 32'h7FFF_FFFF, 0, 0), 1,
			make_res(0, 32'h7FFF_FFFF, 0, 0, 1)});
		directed.push_back('{make_op(ACT_NORM, 32'h8000_0000, 0, 0), 1,
			make_res(0, 32'h7FFF_FFFF, 0, 0, 1)});
		directed.push_back('{make_op(ACT_EQUAL, 32'h8000_0000, 32'h8000_0000, 0), 1,
			make_res(0, 0, 1, 0, 0)});
		directed.push_back('{make_op(ACT_EQUAL, 32'h0000_0001, 32'h0000_0002, 0), 1, none});
		directed.push_back('{make_op(action_t'(4'hF), 32'h7FFF_FFFF, 32'h8000_0000, 5), 1,
			none});
		directed.push_back('{make_op(ACT_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 0), 1, none});
		// Remaining actions, checked by the model
		directed.push_back('{make_op(ACT_SCALE, 32'h8000_0000, 0, 32'h8000_0000), 0, none});
		directed.push_back('{make_op(ACT_SCALE, 32'hFFFF_FFFF, 0, 32'h0000_0001), 0, none});
		directed.push_back('{make_op(ACT_DIV, 32'h8000_0000, 0, 32'hFFFF_FFFF), 0, none});
		directed.push_back('{make_op(ACT_DIV, 32'h0005_0000, 0, 32'hFFFE_0000), 0, none});
		directed.push_back('{make_op(ACT_DOT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0), 0, none});
		directed.push_back('{make_op(ACT_DOT, 32'h0001_8000, 32'hFFFF_4000, 0), 0, none});
		op = make_op(ACT_CROSS, 0, 0, 0);
		op.a = {32'h7FFF_FFFF, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000};
		op.b = {32'h8000_0000, 32'h0006_0000, 32'h0005_0000, 32'h0004_0000};
		directed.push_back('{op, 0, none});
		directed.push_back('{make_op(ACT_CROSS, 32'h8000_0000, 32'h7FFF_FFFF, 0), 0, none});
		op.act = ACT_NORMALIZE;
		directed.push_back('{op, 0, none});
		directed.push_back('{make_op(ACT_NORMALIZE, 32'h0000_0001, 0, 0), 0, none});
		directed.push_back('{make_op(ACT_NORM, 32'h0001_0000, 0, 0), 0, none});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k])
			send_op(directed[k].op, directed[k].typed, directed[k].want);

		// Walk the tolerance through both extremes, the reset value and random settings
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_tolerance('0);
				1: set_tolerance(16'hFFFF);
				2: set_tolerance(EPS_RESET);
				default: set_tolerance(16'($urandom_range(0, 16'hFFFF)));
			endcase
			// equal with zero tolerance is never true
			if (p == 0)
				send_op(make_op(ACT_EQUAL, 32'h55, 32'h55, 0), 1, none);
			for (int k = 0; k < PER_PHASE; k++) begin
				if (p == PHASES - 1 && k >= PER_PHASE - 150)
					quiet = 1'b1;
				send_op(random_op(), 0, none);
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0)
			$display("PASS four_component_vector_alu");
		else
			$display("FAIL four_component_vector_alu");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/fcva_pkg.sv
rtl/fcva_lane.sv
rtl/fcva_sqrt.sv
rtl/fcva_div.sv
rtl/fcva_merge.sv
rtl/four_component_vector_alu.sv
dv/tb_four_component_vector_alu.sv
